// ===== rtl/core/cbts_pkg.sv =====
// ----------------------------------------------------------------------------
// cbts_pkg
// Shared types, constants and the substitution lookup of the triplet encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbts_pkg;

  localparam int unsigned CodeW   = 7;   // character code width
  localparam int unsigned GroupW  = 3;   // one output group
  localparam int unsigned MapW    = 24;  // eight 3-bit entries
  localparam int unsigned AccW    = 9;   // two leftover bits plus seven code bits
  localparam int unsigned MaxGrp  = 3;

  localparam logic [MapW-1:0] MAP_RESET = 24'd2177406;

  typedef logic [GroupW-1:0] group_t;

  // Up to three substituted groups formed from one character.
  // Entry 0 is sent first.
  typedef struct packed {
    logic [MaxGrp-1:0][GroupW-1:0] codes;
    logic [1:0]                    count;
    logic                          last;
  } groups_t;

  // Leftover bits carried to the next character.
  typedef struct packed {
    logic [1:0] bits;
    logic [1:0] count;
  } pend_t;

  function automatic group_t substitute(input logic [MapW-1:0] map,
                                        input group_t idx);
    return map[GroupW*idx +: GroupW];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cbts_grouper.sv =====
// ----------------------------------------------------------------------------
// cbts_grouper
// Joins leftover bits with one character and cuts the result into groups.
// ----------------------------------------------------------------------------
`default_nettype none

module cbts_grouper (
  input  wire logic [cbts_pkg::CodeW-1:0] char_code,
  input  wire logic                       end_of_string,
  input  wire logic [cbts_pkg::MapW-1:0]  map_table,
  input  wire cbts_pkg::pend_t            pend,
  output cbts_pkg::groups_t               groups,
  output cbts_pkg::pend_t                 pend_next
);

  logic [2:0]                   len;
  logic [1:0]                   pc;
  logic [1:0]                   pb;
  logic [cbts_pkg::AccW-1:0]    acc;
  logic [3:0]                   total;
  logic [3:0]                   shamt;
  logic [cbts_pkg::AccW-1:0]    aligned;
  logic [1:0]                   full;
  logic [1:0]                   rem;

  // Significant bit count of the code; a zero code still counts one bit.
  always_comb begin
    if (char_code[6])      len = 3'd7;
    else if (char_code[5]) len = 3'd6;
    else if (char_code[4]) len = 3'd5;
    else if (char_code[3]) len = 3'd4;
    else if (char_code[2]) len = 3'd3;
    else if (char_code[1]) len = 3'd2;
    else                   len = 3'd1;
  end

  always_comb begin
    pc = (pend.count == 2'd3) ? 2'd2 : pend.count;
    case (pc)
      2'd0:    pb = 2'b00;
      2'd1:    pb = {1'b0, pend.bits[0]};
      default: pb = pend.bits;
    endcase
    acc   = ({7'd0, pb} << len) | {2'd0, char_code};
    total = {2'd0, pc} + {1'b0, len};
    // Left-align so groups sit at fixed places and padding zeros come free.
    shamt   = 4'd9 - total;
    aligned = acc << shamt;
    if (total >= 4'd9) begin
      full = 2'd3;
      rem  = 2'(total - 4'd9);
    end else if (total >= 4'd6) begin
      full = 2'd2;
      rem  = 2'(total - 4'd6);
    end else if (total >= 4'd3) begin
      full = 2'd1;
      rem  = 2'(total - 4'd3);
    end else begin
      full = 2'd0;
      rem  = total[1:0];
    end
  end

  always_comb begin
    groups.codes[0] = cbts_pkg::substitute(map_table, aligned[8:6]);
    groups.codes[1] = cbts_pkg::substitute(map_table, aligned[5:3]);
    groups.codes[2] = cbts_pkg::substitute(map_table, aligned[2:0]);
    groups.count    = (end_of_string && rem != 2'd0) ? full + 2'd1 : full;
    groups.last     = end_of_string;
    if (end_of_string) begin
      pend_next.bits  = 2'b00;
      pend_next.count = 2'd0;
    end else begin
      pend_next.count = rem;
      case (rem)
        2'd0:    pend_next.bits = 2'b00;
        2'd1:    pend_next.bits = {1'b0, acc[0]};
        default: pend_next.bits = acc[1:0];
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbts_result_q.sv =====
// ----------------------------------------------------------------------------
// cbts_result_q
// Result register that sends the groups of one character, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cbts_result_q (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire cbts_pkg::groups_t             groups,
  output logic                               free,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cbts_pkg::GroupW-1:0]        code_group,
  output logic                               last_group
);

  logic [cbts_pkg::MaxGrp-1:0][cbts_pkg::GroupW-1:0] codes;
  logic [1:0] count;
  logic       last;
  logic       pop;

  assign out_valid  = (count != 2'd0);
  assign pop        = out_valid && out_ready;
  assign free       = (count == 2'd0) || (count == 2'd1 && out_ready);
  assign code_group = codes[0];
  assign last_group = last && (count == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= groups.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      codes <= groups.codes;
      last  <= groups.last;
    end else if (pop) begin
      codes <= codes >> cbts_pkg::GroupW;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result register loaded while groups still pending");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> count == $past(groups.count))
    else $error("group count not taken on load");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !load && count > 2'd1) |=> (out_valid && count == $past(count) - 2'd1))
    else $error("group lost or repeated after a transaction");

endmodule

`default_nettype wire

// ===== rtl/core/char_bits_triplet_substitution_encoder_top.sv =====
// ----------------------------------------------------------------------------
// char_bits_triplet_substitution_encoder_top
// Encodes 7-bit characters as a stream of substituted 3-bit groups.
// ----------------------------------------------------------------------------
// Flow: an accepted character waits in the input register, then its groups are
//   loaded into the result register once that register is free and sent from
//   there in order, each held until taken. A character with no group leaves the
//   input register without loading the result register. The single result port
//   sends one group at a time, while a new character can already be accepted.
// Reset (synchronous, rst high): carry cleared, default map, both buffers empty.
`default_nettype none

module char_bits_triplet_substitution_encoder_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Character input channel.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cbts_pkg::CodeW-1:0]    char_code,
  input  wire logic                          end_of_string,
  // Group output channel.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cbts_pkg::GroupW-1:0]        code_group,
  output logic                               last_group,
  // Map table write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cbts_pkg::MapW-1:0]     cfg_data
);

  // The map table register; writes are always taken.
  logic [cbts_pkg::MapW-1:0] map_table;

  // Input register: holds one accepted character until its groups can be
  // placed in the result register.
  logic                       hold_valid;
  logic [cbts_pkg::CodeW-1:0] hold_code;
  logic                       hold_end;

  // Leftover bits from earlier characters of the current string.
  cbts_pkg::pend_t   pend;
  cbts_pkg::pend_t   pend_next;
  cbts_pkg::groups_t groups;

  logic q_free;
  logic take;
  logic load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_table <= cbts_pkg::MAP_RESET;
    end else if (cfg_valid) begin
      map_table <= cfg_data;
    end
  end

  cbts_grouper u_grouper (
    .char_code     (hold_code),
    .end_of_string (hold_end),
    .map_table     (map_table),
    .pend          (pend),
    .groups        (groups),
    .pend_next     (pend_next)
  );

  // A held character moves on when the result register can take its groups,
  // or at once when it produces none.
  assign take     = hold_valid && (q_free || groups.count == 2'd0);
  assign load     = take && (groups.count != 2'd0);
  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_code <= char_code;
      hold_end  <= end_of_string;
    end
  end

  // The leftover state advances exactly once per character, when it leaves
  // the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (take) begin
      pend <= pend_next;
    end
  end

  cbts_result_q u_result_q (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .groups     (groups),
    .free       (q_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_group (code_group),
    .last_group (last_group)
  );

endmodule

`default_nettype wire
